// ===== rtl/core/sorted_priority_queue_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// shared constants and types of the sorted priority queue
`default_nettype none

package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;
   localparam int FILL_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] max_value;
      logic [COUNT_W-1:0]        count;
      logic                      empty_res;
      logic                      error;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/spq_if.sv =====
// request and response channel interfaces of the sorted priority queue
`default_nettype none

interface spq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic signed [spq_pkg::VALUE_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

interface spq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [spq_pkg::VALUE_W-1:0] max_value;
   logic [spq_pkg::COUNT_W-1:0]        count;
   logic                               empty_res;
   logic                               error;

   modport source (output valid, output max_value, output count, output empty_res,
                   output error, input ready);
   modport sink (input valid, input max_value, input count, input empty_res,
                 input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spq_datapath.sv =====
// sorted store with parallel compare and shift, fill count and result register
`default_nettype none

module spq_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire spq_pkg::cmd_type                   cmd,
   input  wire logic                               req_func,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] req_value,
   output spq_pkg::result_type                     result
);

   logic                               func_ff;
   logic signed [spq_pkg::VALUE_W-1:0] value_ff;
   logic signed [spq_pkg::VALUE_W-1:0] entries_ff [spq_pkg::DEPTH];
   logic signed [spq_pkg::VALUE_W-1:0] entries_in [spq_pkg::DEPTH];
   logic [spq_pkg::FILL_W-1:0]         fill_ff;
   logic [spq_pkg::FILL_W-1:0]         fill_in;
   spq_pkg::result_type                result_ff;
   spq_pkg::result_type                result_in;
   logic [spq_pkg::DEPTH-1:0]          ge;
   logic                               is_insert;
   logic                               full;
   logic                               empty;
   logic                               err;

   assign is_insert = (func_ff == spq_pkg::FUNC_INSERT);
   assign full      = (fill_ff == spq_pkg::FILL_W'(spq_pkg::DEPTH));
   assign empty     = (fill_ff == '0);
   assign err       = is_insert ? full : empty;

   // valid entries at or above the new value; a prefix since the store is sorted
   always_comb begin
      for (int i = 0; i < spq_pkg::DEPTH; i++) begin
         ge[i] = (spq_pkg::FILL_W'(i) < fill_ff) && (entries_ff[i] >= value_ff);
      end
   end

   always_comb begin
      if (is_insert) begin
         entries_in[0] = ge[0] ? entries_ff[0] : value_ff;
         for (int i = 1; i < spq_pkg::DEPTH; i++) begin
            if (ge[i]) begin
               entries_in[i] = entries_ff[i];
            end else if (ge[i-1]) begin
               entries_in[i] = value_ff;
            end else begin
               entries_in[i] = entries_ff[i-1];
            end
         end
         fill_in = fill_ff + spq_pkg::FILL_W'(1);
      end else begin
         for (int i = 0; i < spq_pkg::DEPTH - 1; i++) begin
            entries_in[i] = entries_ff[i+1];
         end
         entries_in[spq_pkg::DEPTH-1] = entries_ff[spq_pkg::DEPTH-1];
         fill_in = fill_ff - spq_pkg::FILL_W'(1);
      end
   end

   always_comb begin
      if (err) begin
         result_in.max_value = empty ? '0 : entries_ff[0];
         result_in.count     = spq_pkg::COUNT_W'(fill_ff);
         result_in.empty_res = empty;
      end else begin
         result_in.max_value = (fill_in != '0) ? entries_in[0] : '0;
         result_in.count     = spq_pkg::COUNT_W'(fill_in);
         result_in.empty_res = (fill_in == '0);
      end
      result_in.error = err;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (cmd.execute && !err) begin
         for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
      if (cmd.execute) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.execute && !err) begin
         fill_ff <= fill_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
// controller: sequences capture, update and delivery of one item
`default_nettype none

module spq_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output spq_pkg::cmd_type  cmd
);

   spq_pkg::state_type state_ff;
   spq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = spq_pkg::ST_EXEC;
            end
         end
         spq_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = spq_pkg::ST_RESP;
         end
         spq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = spq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// sorted priority queue: 16 signed entries kept in descending order
// sequence: the accepting edge captures the request, the update edge writes the store and
// the result register, then the result is offered until taken; a new item is taken only
// after the last result is taken, set by the capture / update / deliver sequence of the controller
// reset: synchronous; clears the fill count and controller state, store content is left
`default_nettype none

module sorted_priority_queue (
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   spq_pkg::cmd_type    cmd;
   spq_pkg::result_type result;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   spq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_func  (req_chan.func),
      .req_value (req_chan.value),
      .result    (result)
   );

   assign rsp_chan.max_value = result.max_value;
   assign rsp_chan.count     = result.count;
   assign rsp_chan.empty_res = result.empty_res;
   assign rsp_chan.error     = result.error;

endmodule

`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// port-level checker of the sorted priority queue and its bind
`default_nettype none

`include "sorted_priority_queue_macros.svh"

module spq_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [spq_pkg::VALUE_W-1:0] rsp_max_value,
   input wire logic [spq_pkg::COUNT_W-1:0]        rsp_count,
   input wire logic                               rsp_empty_res,
   input wire logic                               rsp_error
);

   `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_max_value) && $stable(rsp_count) && $stable(rsp_empty_res) && $stable(rsp_error), "stalled result changed")
   `SPQ_ASSERT_SAME(a_one_item, rsp_valid, !req_ready, "new item taken while result pending")
   `SPQ_ASSERT_SAME(a_empty_zero, rsp_valid && rsp_empty_res, (rsp_count == '0) && (rsp_max_value == '0), "empty result with count or maximum set")
   `SPQ_ASSERT_SAME(a_empty_flag, rsp_valid, rsp_empty_res == (rsp_count == '0), "empty flag disagrees with count")
   `SPQ_ASSERT_SAME(a_error_bound, rsp_valid && rsp_error, (rsp_count == '0) || (rsp_count == spq_pkg::COUNT_W'(spq_pkg::DEPTH)), "error without empty or full queue")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_max_value (rsp_chan.max_value),
   .rsp_count     (rsp_chan.count),
   .rsp_empty_res (rsp_chan.empty_res),
   .rsp_error     (rsp_chan.error)
);

`default_nettype wire

// ===== verif/sorted_priority_queue_tb.sv =====
// testbench of the sorted priority queue: directed table, random traffic, scoreboard
`default_nettype none

module sorted_priority_queue_tb;

   localparam logic [spq_pkg::VALUE_W-1:0] MAX_V = 32'h7fffffff;
   localparam logic [spq_pkg::VALUE_W-1:0] MIN_V = 32'h80000000;
   localparam int RANDOM_PER_PHASE = 284;
   localparam int LONG_HOLD = 150;

   typedef struct packed {
      spq_pkg::func_type           op;
      logic [spq_pkg::VALUE_W-1:0] value;
      logic                        typed;
      logic [spq_pkg::VALUE_W-1:0] max_value;
      logic [spq_pkg::COUNT_W-1:0] count;
      logic                        empty_res;
      logic                        error;
   } stim_row_type;

   // expected status is typed in only on rows that read off at a glance
   localparam stim_row_type DIRECTED [24] = '{
      '{spq_pkg::FUNC_REMOVE, 32'h00000000, 1'b1, 32'h0,  5'd0, 1'b1, 1'b1},
      '{spq_pkg::FUNC_REMOVE, 32'hffffffff, 1'b1, 32'h0,  5'd0, 1'b1, 1'b1},
      '{spq_pkg::FUNC_INSERT, MIN_V,        1'b1, MIN_V,  5'd1, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, MAX_V,        1'b1, MAX_V,  5'd2, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000000, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000000, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'hffffffff, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000001, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, MAX_V,        1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, MIN_V,        1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_REMOVE, 32'h5a5a5a5a, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000005, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'hfffffffb, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000064, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'hffffff9c, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000007, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000007, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h40000000, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'hfffffff9, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000003, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h0000002a, 1'b1, MAX_V,  5'd16, 1'b0, 1'b1},
      '{spq_pkg::FUNC_REMOVE, 32'ha5a5a5a5, 1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, MIN_V,        1'b0, 32'h0,  5'd0, 1'b0, 1'b0},
      '{spq_pkg::FUNC_INSERT, 32'h00000000, 1'b1, 32'h40000000, 5'd16, 1'b0, 1'b1}
   };

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   sorted_priority_queue i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predictor state: values in descending order
   logic signed [spq_pkg::VALUE_W-1:0] sorted_vals [spq_pkg::DEPTH];
   int                                 sorted_count;
   spq_pkg::result_type                awaited_status [$];

   int   send_idle;
   int   recv_idle;
   logic hold_kick;
   logic hold_taken;
   int   hold_left;
   int   mismatches;
   int   result_index;

   always #5 clock = ~clock;

   function automatic spq_pkg::result_type apply_queue_op(
         spq_pkg::func_type op, logic signed [spq_pkg::VALUE_W-1:0] v);
      spq_pkg::result_type r;
      int                  pos;
      r.error = 1'b0;
      if (op == spq_pkg::FUNC_INSERT) begin
         if (sorted_count >= spq_pkg::DEPTH) begin
            r.error = 1'b1;
         end else begin
            pos = 0;
            // equal values keep arrival order
            while (pos < sorted_count && sorted_vals[pos] >= v) pos++;
            for (int i = sorted_count; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
            sorted_vals[pos] = v;
            sorted_count++;
         end
      end else begin
         if (sorted_count == 0) begin
            r.error = 1'b1;
         end else begin
            for (int i = 1; i < sorted_count; i++) sorted_vals[i-1] = sorted_vals[i];
            sorted_count--;
         end
      end
      r.max_value = (sorted_count > 0) ? sorted_vals[0] : '0;
      r.count     = sorted_count[spq_pkg::COUNT_W-1:0];
      r.empty_res = (sorted_count == 0);
      return r;
   endfunction

   task automatic drive_item(spq_pkg::func_type op, logic [spq_pkg::VALUE_W-1:0] v,
                             logic typed, spq_pkg::result_type typed_status);
      spq_pkg::result_type predicted;
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= op;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = apply_queue_op(op, v);
      awaited_status.push_back(typed ? typed_status : predicted);
   endtask

   task automatic report_mismatch(string field, logic [spq_pkg::VALUE_W-1:0] got,
                                  logic [spq_pkg::VALUE_W-1:0] want);
      $display("result %0d: %s is %0h, expected %0h", result_index, field, got, want);
      mismatches++;
   endtask

   // receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         hold_taken   <= 1'b0;
         hold_left    <= 0;
         rsp_if.ready <= 1'b0;
      end else if (hold_kick && !hold_taken) begin
         hold_taken   <= 1'b1;
         hold_left    <= LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      spq_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_status.size() == 0) begin
            report_mismatch("outstanding", spq_pkg::VALUE_W'(0), spq_pkg::VALUE_W'(1));
         end else begin
            want = awaited_status.pop_front();
            if (rsp_if.max_value !== want.max_value)
               report_mismatch("max_value", rsp_if.max_value, want.max_value);
            if (rsp_if.count !== want.count)
               report_mismatch("count", spq_pkg::VALUE_W'(rsp_if.count),
                               spq_pkg::VALUE_W'(want.count));
            if (rsp_if.empty_res !== want.empty_res)
               report_mismatch("empty_res", spq_pkg::VALUE_W'(rsp_if.empty_res),
                               spq_pkg::VALUE_W'(want.empty_res));
            if (rsp_if.error !== want.error)
               report_mismatch("error", spq_pkg::VALUE_W'(rsp_if.error),
                               spq_pkg::VALUE_W'(want.error));
         end
         result_index++;
      end
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      spq_pkg::result_type         typed_status;
      spq_pkg::func_type           op;
      logic [spq_pkg::VALUE_W-1:0] v;
      int                          insert_pct;
      int                          seg_left;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.func  = spq_pkg::FUNC_INSERT;
      req_if.value = '0;
      hold_kick    = 1'b0;
      send_idle    = 11;
      recv_idle    = 85;
      mismatches   = 0;
      result_index = 0;
      sorted_count = 0;
      insert_pct   = 50;
      seg_left     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[k]) begin
         typed_status.max_value = DIRECTED[k].max_value;
         typed_status.count     = DIRECTED[k].count;
         typed_status.empty_res = DIRECTED[k].empty_res;
         typed_status.error     = DIRECTED[k].error;
         drive_item(DIRECTED[k].op, DIRECTED[k].value, DIRECTED[k].typed, typed_status);
      end

      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // drift between filling, churning and draining
            if (seg_left == 0) begin
               seg_left = $urandom_range(60, 20);
               case ($urandom_range(2))
                  0:       insert_pct = 15;
                  1:       insert_pct = 50;
                  default: insert_pct = 85;
               endcase
            end
            seg_left--;
            if (phase == 2 && n == 40) hold_kick <= 1'b1;
            op = ($urandom_range(99) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                   : spq_pkg::FUNC_REMOVE;
            case ($urandom_range(9))
               0: begin
                  case ($urandom_range(3))
                     0:       v = MAX_V;
                     1:       v = MIN_V;
                     2:       v = '0;
                     default: v = '1;
                  endcase
               end
               1, 2, 3, 4: v = $urandom_range(16) - 8;
               default:    v = $urandom();
            endcase
            drive_item(op, v, 1'b0, '0);
         end
         // let the queue drain before the idle pattern changes
         req_if.valid <= 1'b0;
         while (awaited_status.size() != 0) @(posedge clock);
         if (phase == 0) begin
            send_idle = 85;
            recv_idle = 11;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && awaited_status.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
